@@ rtl/rau_pkg.sv @@
`timescale 1ns / 1ps
package rau_pkg;

    localparam int OPW  = 16;
    localparam int PW   = 2 * OPW;
    localparam int NW   = PW + 1;
    localparam int NUMW = 33;
    localparam int DENW = 32;
    localparam int CW   = $clog2(NW + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic [1:0]            func;
        logic signed [OPW-1:0] a_num;
        logic signed [OPW-1:0] a_den;
        logic signed [OPW-1:0] b_num;
        logic signed [OPW-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [NUMW-1:0] res_num;
        logic signed [DENW-1:0] res_den;
        logic                   zero_gcd_error;
    } t_out;

    // Datapath commands from the controller.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic form;
        logic div_start;
        logic div_step;
        logic rem_take;
        logic q_num;
        logic q_den;
        logic publish;
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic y_zero;
        logic g_zero;
        logic div_last;
    } t_sts;

endpackage

@@ rtl/rational_arith_unit.sv @@
`timescale 1ns / 1ps
// Exact add, subtract, multiply or divide of two 16-bit fractions, reduced by
// a gcd found with Euclid's algorithm on truncating remainders, so signs follow
// C. Both raw parts zero gives 0/0 with zero_gcd_error set. One transaction is
// worked at a time: it is accepted and its products formed, then each Euclid
// step runs on the one-bit-a-cycle restoring divider, then the two quotients
// are found and moved to the output register. A finished result waits in its
// own register, so the next transaction can be taken while it waits.
module rational_arith_unit
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rau_datapath u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_item (i_in_data),
        .o_sts  (sts),
        .o_res  (o_out_data)
    );

endmodule

@@ rtl/rau_datapath.sv @@
`timescale 1ns / 1ps
module rau_datapath
    import rau_pkg::*;
(
    input  logic i_clk,
    input  t_cmd i_cmd,
    input  t_in  i_item,
    output t_sts o_sts,
    output t_out o_res
);

    logic [1:0]             r_func;
    logic signed [OPW-1:0]  r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0]   r_p0, r_p1, r_pd;
    logic signed [NW-1:0]   r_n, r_d, r_x, r_y;
    logic [NW-1:0]          r_rem, r_quo, r_dsr;
    logic                   r_qneg, r_rneg;
    logic [CW-1:0]          r_cnt;
    logic signed [NUMW-1:0] r_rnum;
    logic signed [DENW-1:0] r_rden;
    logic                   r_err;
    t_out                   r_out;

    logic signed [OPW-1:0]  m0a, m0b, m1a, m1b;
    logic signed [PW-1:0]   prod0, prod1;
    logic signed [NW-1:0]   dvd, dvs, nform;
    logic [NW-1:0]          absd, abss, trial, remsh, qres, rres;

    // Operand selection for the two multipliers, used in MUL1 and MUL2.
    always_comb begin
        m0a = r_an;
        m0b = r_bd;
        m1a = r_ad;
        m1b = r_bn;
        if (i_cmd.mul2) begin
            m0a = r_ad;
            m0b = (r_func == OP_DIV) ? r_bn : r_bd;
            m1a = r_an;
            m1b = r_bn;
        end
    end

    assign prod0 = PW'(m0a * m0b);
    assign prod1 = PW'(m1a * m1b);

    // Raw numerator from the registered products (r_pd for a multiply).
    always_comb begin
        unique case (r_func)
            OP_ADD:  nform = NW'(r_p0) + NW'(r_p1);
            OP_SUB:  nform = NW'(r_p0) - NW'(r_p1);
            OP_MUL:  nform = NW'(r_pd);
            default: nform = NW'(r_p0);
        endcase
    end

    // Dividend and divisor for the shared serial divider.
    always_comb begin
        dvd = r_x;
        dvs = r_y;
        if (i_cmd.q_num) begin
            dvd = r_n;
            dvs = r_x;
        end else if (i_cmd.q_den) begin
            dvd = r_d;
            dvs = r_x;
        end
    end

    assign absd  = dvd[NW-1] ? NW'(-dvd) : dvd;
    assign abss  = dvs[NW-1] ? NW'(-dvs) : dvs;
    assign remsh = {r_rem[NW-2:0], r_quo[NW-1]};
    assign trial = remsh - r_dsr;
    assign qres  = r_qneg ? NW'(-r_quo) : r_quo;
    assign rres  = r_rneg ? NW'(-r_rem) : r_rem;

    // Restoring divider, one quotient bit a cycle, plus Euclid registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_item.func;
            r_an   <= i_item.a_num;
            r_ad   <= i_item.a_den;
            r_bn   <= i_item.b_num;
            r_bd   <= i_item.b_den;
        end
        if (i_cmd.mul1) begin
            r_p0 <= prod0;
            r_p1 <= prod1;
        end
        if (i_cmd.mul2) begin
            r_pd <= prod1;
            r_d  <= NW'(prod0);
            r_y  <= NW'(prod0);
        end
        if (i_cmd.form) begin
            r_n <= nform;
            r_x <= nform;
        end
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_quo  <= absd;
            r_dsr  <= abss;
            r_qneg <= dvd[NW-1] ^ dvs[NW-1];
            r_rneg <= dvd[NW-1];
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!trial[NW-1] || remsh[NW-1]) begin
                r_rem <= trial;
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= remsh;
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
        if (i_cmd.rem_take) begin
            r_x <= r_y;
            r_y <= rres;
        end
        if (i_cmd.q_num) begin
            r_rnum <= NUMW'(qres);
            r_err  <= 1'b0;
        end
        if (i_cmd.q_den) begin
            r_rden <= DENW'(qres);
        end
        if (i_cmd.load) begin
            r_err <= 1'b1;
            r_rnum <= '0;
            r_rden <= '0;
        end
    end

    // Output register, loaded once the result is complete.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out.res_num        <= r_rnum;
            r_out.res_den        <= r_rden;
            r_out.zero_gcd_error <= r_err;
        end
    end

    assign o_sts.y_zero   = (r_y == '0);
    assign o_sts.g_zero   = (r_x == '0);
    assign o_sts.div_last = (r_cnt == CW'(NW - 1));

    assign o_res = r_out;

endmodule

@@ rtl/rau_ctrl.sv @@
`timescale 1ns / 1ps
module rau_ctrl
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL1  = 9'b000000010,
        S_MUL2  = 9'b000000100,
        S_FORM  = 9'b000001000,
        S_TEST  = 9'b000010000,
        S_RSTEP = 9'b000100000,
        S_QNUM  = 9'b001000000,
        S_QDEN  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_run, n_run;   // second phase of the state: a divide finished, or in QDEN one running
    logic   r_ovalid, n_ovalid;
    logic   in_acc;

    // A new transaction is taken while the previous result still waits.
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_run    = r_run;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_FORM;
            end
            S_FORM: begin
                o_cmd.form = 1'b1;
                n_state    = S_TEST;
            end
            S_TEST: begin
                if (!i_sts.y_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_RSTEP;
                end else if (i_sts.g_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.q_num     = 1'b1;
                    n_state         = S_QNUM;
                end
            end
            S_RSTEP: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_TEST;
                    n_run   = 1'b1;
                end
            end
            S_QNUM: begin
                if (!r_run) begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_last) n_run = 1'b1;
                end else begin
                    o_cmd.q_num     = 1'b1;
                    o_cmd.q_den     = 1'b0;
                    o_cmd.div_start = 1'b0;
                    n_run           = 1'b0;
                    n_state         = S_QDEN;
                end
            end
            S_QDEN: begin
                if (!r_run) begin
                    o_cmd.q_den     = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_run           = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Capture D/g first when its divide ran, then move the result to the output register.
                if (r_run) begin
                    o_cmd.q_den = 1'b1;
                    n_run       = 1'b0;
                end else if (!r_ovalid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_ovalid      = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // The remainder of a finished Euclid step is taken back in TEST.
        if (r_state == S_TEST && r_run) begin
            o_cmd.rem_take  = 1'b1;
            o_cmd.div_start = 1'b0;
            o_cmd.q_num     = 1'b0;
            n_state         = S_TEST;
            n_run           = 1'b0;
        end
        // Quotient N/g captures once its divide finishes.
        if (r_state == S_QNUM && r_run) begin
            o_cmd.q_num = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

@@ rtl/rau_checker.sv @@
`timescale 1ns / 1ps
module rau_checker
    import rau_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // A result holds until its transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Ready drops in the cycle after an item is accepted.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accept");

    // The error flag comes only with a 0/0 result.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_gcd_error |->
        o_out_data.res_num == '0 && o_out_data.res_den == '0)
        else $error("error flag with nonzero result");

    // A non-error result never has a zero numerator and denominator together.
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.zero_gcd_error |->
        o_out_data.res_num != '0 || o_out_data.res_den != '0)
        else $error("0/0 result without error flag");

endmodule

bind rational_arith_unit rau_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ tb/sv/tb_rational_arith_unit.sv @@
`timescale 1ns / 1ps
module tb_rational_arith_unit;
    import rau_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 2000;
    localparam int RANDOM_ITEMS = 350;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    rational_arith_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    t_in  pending_ops[$];
    t_out expected_fracs[$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   error_count;
    int   results_seen;
    int   idle_cycles;
    bit   timed_out;
    bit   stim_done;

    // Truncating quotient and remainder on 64-bit signed values.
    function automatic longint trunc_rem(longint x, longint y);
        if (y == 1 || y == -1) return 0;
        return x % y;
    endfunction

    function automatic longint trunc_quot(longint x, longint y);
        if (y == -1) return -x;
        return x / y;
    endfunction

    // Reduced fraction from the exact raw numerator and denominator.
    function automatic t_out reduce_fraction(t_in op);
        longint an, ad, bn, bd, n, d, x, y, r;
        t_out   res;
        an = op.a_num;
        ad = op.a_den;
        bn = op.b_num;
        bd = op.b_den;
        d  = ad * bd;
        case (op.func)
            OP_ADD:  n = an * bd + ad * bn;
            OP_SUB:  n = an * bd - ad * bn;
            OP_MUL:  n = an * bn;
            default: begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        x = n;
        y = d;
        while (y != 0) begin
            r = trunc_rem(x, y);
            x = y;
            y = r;
        end
        res = '0;
        if (x == 0) begin
            res.zero_gcd_error = 1'b1;
        end else begin
            res.res_num = NUMW'(trunc_quot(n, x));
            res.res_den = DENW'(trunc_quot(d, x));
        end
        return res;
    endfunction

    function automatic logic [15:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 6)) - 3);
            3: return 16'($urandom_range(0, 40)) * 16'($urandom_range(0, 1) ? 1 : -1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_op(logic [1:0] f, int an, int ad, int bn, int bd);
        t_in op;
        op.func  = f;
        op.a_num = 16'(an);
        op.a_den = 16'(ad);
        op.b_num = 16'(bn);
        op.b_den = 16'(bd);
        pending_ops.push_back(op);
    endtask

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stimulus: directed corner cases, then random phases with varied idling and stalling.
    initial begin
        t_in op;
        i_rst_n        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stim_done      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_op(OP_ADD, 1, 2, 1, 3);
        queue_op(OP_SUB, 1, 2, 1, 2);
        queue_op(OP_MUL, -3, 4, 8, -9);
        queue_op(OP_DIV, 2, 3, -4, 5);
        queue_op(OP_ADD, 0, 0, 0, 0);
        queue_op(OP_MUL, 0, 5, 7, 0);
        queue_op(OP_DIV, 5, 1, 0, 1);
        queue_op(OP_DIV, 0, 1, 0, 1);
        queue_op(OP_ADD, 7, 0, 3, 1);
        queue_op(OP_SUB, -32768, -32768, 32767, 32767);
        queue_op(OP_ADD, -32768, 1, -32768, 1);
        queue_op(OP_MUL, -32768, 32767, -32768, 32767);
        queue_op(OP_DIV, 32767, -32768, -32768, 32767);
        queue_op(OP_SUB, 32767, 1, -32768, 1);
        queue_op(OP_MUL, 6, -1, 4, 1);
        queue_op(OP_DIV, -1, -1, -1, -1);
        queue_op(OP_ADD, 32767, -1, 32767, -1);
        queue_op(OP_MUL, 5, -10, 3, 9);
        queue_op(OP_DIV, 21, 13, 8, 5);

        for (int phase = 0; phase < 4; phase++) begin
            wait (pending_ops.size() == 0);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
                op.func  = 2'($urandom_range(0, 3));
                op.a_num = rand_operand();
                op.a_den = rand_operand();
                op.b_num = rand_operand();
                op.b_den = rand_operand();
                pending_ops.push_back(op);
            end
        end
        wait (pending_ops.size() == 0);
        stim_done = 1'b1;
    end

    // Driver: present the next pending transaction, with random idle cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                expected_fracs.push_back(reduce_fraction(i_in_data));
                void'(pending_ops.pop_front());
            end
            if (pending_ops.size() > 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_ops[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_fracs.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result %h", $time, o_out_data);
                end else begin
                    exp_res = expected_fracs.pop_front();
                    if (o_out_data.res_num !== exp_res.res_num) begin
                        error_count++;
                        $display("%0t: res_num expected %0d actual %0d", $time,
                                 exp_res.res_num, o_out_data.res_num);
                    end
                    if (o_out_data.res_den !== exp_res.res_den) begin
                        error_count++;
                        $display("%0t: res_den expected %0d actual %0d", $time,
                                 exp_res.res_den, o_out_data.res_den);
                    end
                    if (o_out_data.zero_gcd_error !== exp_res.zero_gcd_error) begin
                        error_count++;
                        $display("%0t: zero_gcd_error expected %b actual %b", $time,
                                 exp_res.zero_gcd_error, o_out_data.zero_gcd_error);
                    end
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) timed_out <= 1'b1;
    end

    initial begin
        error_count  = 0;
        results_seen = 0;
        idle_cycles  = 0;
        timed_out    = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_out_ready  = 1'b0;
        wait ((stim_done && expected_fracs.size() == 0 && !i_in_valid) || timed_out);
        if (!timed_out) begin
            repeat (DRAIN_WAIT) @(posedge i_clk);
        end
        $display("Checked %0d results: directed corners plus random operands",
                 results_seen);
        $display("over all four operations under four idle and stall patterns.");
        if (!timed_out && error_count == 0 && expected_fracs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
